// ===== rtl/core/arcade_drive_trig_mixer_defines.svh =====
// ---------------------------------------------------------------------------
// Arcade drive mixer assertion macros
// Clocked on clk, disabled during rst.
// ---------------------------------------------------------------------------
`ifndef ARCADE_DRIVE_TRIG_MIXER_DEFINES_SVH
`define ARCADE_DRIVE_TRIG_MIXER_DEFINES_SVH
`ifndef SYNTHESIS
`define ADM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ADM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ADM_ASSERT(label, prop, msg)
`define ADM_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/core/adm_pkg.sv =====
// ---------------------------------------------------------------------------
// Arcade drive mixer package
// Number format, widths, register indexes and shared types.
// ---------------------------------------------------------------------------
package adm_pkg;
  localparam int FRAC_BITS = 14;
  localparam int MAG_W     = FRAC_BITS + 1;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int DATA_W    = 16;
  localparam int GAIN_W    = 15;
  localparam int CFG_IDX_W = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW   = $clog2(FIFO_DEPTH);
  localparam logic [MAG_W-1:0] ONE = MAG_W'(1) << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOVE_GAIN_POS   = 2'd0,
    REG_MOVE_GAIN_NEG   = 2'd1,
    REG_ROTATE_GAIN_POS = 2'd2,
    REG_ROTATE_GAIN_NEG = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] r;
    logic             move_neg;
    logic             right_inner;
    logic             zero;
  } mid_t;

  typedef struct packed {
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;
  } res_t;
endpackage

// ===== rtl/core/adm_front.sv =====
// ---------------------------------------------------------------------------
// Arcade drive mixer front end
// Holds the gain registers, scales and clamps both commands, classifies.
// ---------------------------------------------------------------------------
module adm_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [adm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [adm_pkg::GAIN_W-1:0]     cfg_data,
  input  logic signed [adm_pkg::DATA_W-1:0] move_cmd,
  input  logic signed [adm_pkg::DATA_W-1:0] rotate_cmd,
  output adm_pkg::mid_t                  item
);
  import adm_pkg::*;

  localparam int PROD_W = DATA_W + GAIN_W + 1;

  logic [GAIN_W-1:0] move_gain_pos;
  logic [GAIN_W-1:0] move_gain_neg;
  logic [GAIN_W-1:0] rotate_gain_pos;
  logic [GAIN_W-1:0] rotate_gain_neg;

  function automatic logic [MAG_W-1:0] scale_clamp(logic [DATA_W-1:0] cmd,
                                                   logic [GAIN_W-1:0] gain);
    logic [DATA_W-1:0] mag;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] p;
    mag  = cmd[DATA_W-1] ? (~cmd + DATA_W'(1)) : cmd;
    prod = PROD_W'(mag) * PROD_W'(gain) + (PROD_W'(1) << (FRAC_BITS - 1));
    p    = prod >> FRAC_BITS;
    return (p > PROD_W'(ONE)) ? ONE : p[MAG_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      move_gain_pos   <= GAIN_W'(16550);
      move_gain_neg   <= GAIN_W'(27307);
      rotate_gain_pos <= GAIN_W'(16550);
      rotate_gain_neg <= GAIN_W'(16550);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_MOVE_GAIN_POS:   move_gain_pos   <= cfg_data;
        REG_MOVE_GAIN_NEG:   move_gain_neg   <= cfg_data;
        REG_ROTATE_GAIN_POS: rotate_gain_pos <= cfg_data;
        REG_ROTATE_GAIN_NEG: rotate_gain_neg <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    item.move_neg    = move_cmd[DATA_W-1];
    item.a           = scale_clamp(move_cmd,
                         move_cmd[DATA_W-1] ? move_gain_neg : move_gain_pos);
    item.r           = scale_clamp(rotate_cmd,
                         rotate_cmd[DATA_W-1] ? rotate_gain_neg : rotate_gain_pos);
    item.zero        = (item.a == '0);
    item.right_inner = (item.r != '0) && !rotate_cmd[DATA_W-1];
  end
endmodule

// ===== rtl/core/adm_fifo.sv =====
// ---------------------------------------------------------------------------
// Arcade drive mixer request queue
// Short queue between the front end and the back end.
// ---------------------------------------------------------------------------
module adm_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  adm_pkg::mid_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output adm_pkg::mid_t rd_data,
  output logic          empty
);
  import adm_pkg::*;

  mid_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               do_wr;
  logic               do_rd;

  assign full    = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + (FIFO_AW+1)'(do_wr) - (FIFO_AW+1)'(do_rd);
    end
  end
endmodule

// ===== rtl/core/adm_back.sv =====
// ---------------------------------------------------------------------------
// Arcade drive mixer back end
// Square root pipeline, a divider pipeline for both wheels, wheel selection, result queue.
// ---------------------------------------------------------------------------
module adm_back (
  input  logic          clk,
  input  logic          rst,
  input  adm_pkg::mid_t in_item,
  input  logic          in_empty,
  output logic          take,
  output adm_pkg::res_t res,
  output logic          empty,
  input  logic          pop
);
  import adm_pkg::*;
  `include "arcade_drive_trig_mixer_defines.svh"

  localparam int RW = MAG_W + 2;
  localparam int EXT_W = MAG_W + DATA_W;

  typedef struct packed {
    logic [MAG_W-1:0] a;
    logic [SQ_W-1:0]  aa;
    logic [SQ_W-1:0]  ar;
    logic             move_neg;
    logic             right_inner;
    logic             zero;
  } it_t;

  logic              adv;
  logic              pop_fire;
  logic              oq_wr;
  res_t              oq_data;
  res_t              oq [2];
  logic [1:0]        oq_cnt;
  logic [1:0]        oq_left;

  logic              sv    [MAG_W+1];
  it_t               sq_it [MAG_W+1];
  logic [SQ_W-1:0]   sq_v  [MAG_W+1];
  logic [RW-1:0]     sq_rem[MAG_W+1];
  logic [MAG_W-1:0]  sq_root[MAG_W+1];

  logic              dv    [MAG_W+1];
  it_t               dv_it [MAG_W+1];
  logic [MAG_W-1:0]  d_h   [MAG_W+1];
  logic [MAG_W-1:0]  d_ro  [MAG_W+1];
  logic [MAG_W-1:0]  d_ri  [MAG_W+1];
  logic [MAG_W-1:0]  d_no  [MAG_W+1];
  logic [MAG_W-1:0]  d_ni  [MAG_W+1];
  logic [MAG_W-1:0]  d_qo  [MAG_W+1];
  logic [MAG_W-1:0]  d_qi  [MAG_W+1];

  logic [SQ_W-1:0]   num_o;
  logic [SQ_W-1:0]   num_i;

  assign pop_fire = pop && (oq_cnt != 2'd0);
  assign adv      = !(dv[MAG_W] && (oq_cnt == 2'd2) && !pop_fire);
  assign take     = !in_empty && adv;
  assign empty    = (oq_cnt == 2'd0);
  assign res      = oq[0];

  // Entry: square the magnitudes and seed the root
  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_it[0].a           <= in_item.a;
      sq_it[0].aa          <= SQ_W'(in_item.a) * SQ_W'(in_item.a);
      sq_it[0].ar          <= SQ_W'(in_item.a) * SQ_W'(in_item.r);
      sq_it[0].move_neg    <= in_item.move_neg;
      sq_it[0].right_inner <= in_item.right_inner;
      sq_it[0].zero        <= in_item.zero;
      sq_v[0]    <= SQ_W'(in_item.a) * SQ_W'(in_item.a)
                  + SQ_W'(in_item.r) * SQ_W'(in_item.r);
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
    end
  end

  // Root: one result bit per stage
  for (genvar k = 0; k < MAG_W; k++) begin : g_sqrt
    logic [RW-1:0] rsh;
    logic [RW-1:0] trial;
    assign rsh   = {sq_rem[k][MAG_W-1:0], sq_v[k][SQ_W-1 -: 2]};
    assign trial = {sq_root[k], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_it[k+1] <= sq_it[k];
        sq_v[k+1]  <= {sq_v[k][SQ_W-3:0], 2'b00};
        if (rsh >= trial) begin
          sq_rem[k+1]  <= rsh - trial;
          sq_root[k+1] <= {sq_root[k][MAG_W-2:0], 1'b1};
        end else begin
          sq_rem[k+1]  <= rsh;
          sq_root[k+1] <= {sq_root[k][MAG_W-2:0], 1'b0};
        end
      end
    end
  end

  // Divider seed: round half up by adding half the divisor
  assign num_o = sq_it[MAG_W].aa + SQ_W'(sq_root[MAG_W] >> 1);
  assign num_i = sq_it[MAG_W].ar + SQ_W'(sq_root[MAG_W] >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= sv[MAG_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_it[0] <= sq_it[MAG_W];
      d_h[0]   <= sq_root[MAG_W];
      d_ro[0]  <= num_o[SQ_W-1:MAG_W];
      d_ri[0]  <= num_i[SQ_W-1:MAG_W];
      d_no[0]  <= num_o[MAG_W-1:0];
      d_ni[0]  <= num_i[MAG_W-1:0];
      d_qo[0]  <= '0;
      d_qi[0]  <= '0;
    end
  end

  // Division: one quotient bit per stage for both wheels
  for (genvar k = 0; k < MAG_W; k++) begin : g_div
    logic [MAG_W:0] to;
    logic [MAG_W:0] ti;
    logic [MAG_W:0] dd;
    assign to = {d_ro[k], d_no[k][MAG_W-1]};
    assign ti = {d_ri[k], d_ni[k][MAG_W-1]};
    assign dd = {1'b0, d_h[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (adv) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_it[k+1] <= dv_it[k];
        d_h[k+1]   <= d_h[k];
        d_no[k+1]  <= {d_no[k][MAG_W-2:0], 1'b0};
        d_ni[k+1]  <= {d_ni[k][MAG_W-2:0], 1'b0};
        if (to >= dd) begin
          d_ro[k+1] <= MAG_W'(to - dd);
          d_qo[k+1] <= {d_qo[k][MAG_W-2:0], 1'b1};
        end else begin
          d_ro[k+1] <= to[MAG_W-1:0];
          d_qo[k+1] <= {d_qo[k][MAG_W-2:0], 1'b0};
        end
        if (ti >= dd) begin
          d_ri[k+1] <= MAG_W'(ti - dd);
          d_qi[k+1] <= {d_qi[k][MAG_W-2:0], 1'b1};
        end else begin
          d_ri[k+1] <= ti[MAG_W-1:0];
          d_qi[k+1] <= {d_qi[k][MAG_W-2:0], 1'b0};
        end
      end
    end
  end

  // Select wheels, apply sign
  always_comb begin
    logic [MAG_W-1:0] outer;
    logic [MAG_W-1:0] inner;
    logic [MAG_W-1:0] lw;
    logic [MAG_W-1:0] rw;
    logic [EXT_W-1:0] le;
    logic [EXT_W-1:0] re;
    outer = dv_it[MAG_W].zero ? '0 : d_qo[MAG_W];
    inner = dv_it[MAG_W].zero ? '0 : (dv_it[MAG_W].a - d_qi[MAG_W]);
    lw    = dv_it[MAG_W].right_inner ? outer : inner;
    rw    = dv_it[MAG_W].right_inner ? inner : outer;
    le    = EXT_W'(lw);
    re    = EXT_W'(rw);
    if (!dv_it[MAG_W].move_neg) begin
      le = ~le + EXT_W'(1);
      re = ~re + EXT_W'(1);
    end
    oq_data.left  = le[DATA_W-1:0];
    oq_data.right = re[DATA_W-1:0];
  end

  assign oq_wr   = adv && dv[MAG_W];
  assign oq_left = oq_cnt - 2'(pop_fire);

  always_ff @(posedge clk) begin
    if (oq_wr && (oq_left == 2'd0)) begin
      oq[0] <= oq_data;
    end else if (pop_fire) begin
      oq[0] <= oq[1];
    end
    if (oq_wr && (oq_left != 2'd0)) begin
      oq[1] <= oq_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_cnt <= 2'd0;
    end else begin
      oq_cnt <= oq_left + 2'(oq_wr);
    end
  end

  `ADM_ASSERT(a_oq_bound, oq_cnt <= 2'd2, "result queue over depth")
  `ADM_ASSERT(a_oq_full_wr, !(oq_wr && oq_cnt == 2'd2) || pop_fire, "write into full result queue")
  `ADM_ASSERT_NEXT(a_stall_hold, dv[MAG_W] && !adv, dv[MAG_W] && $stable(d_qo[MAG_W]), "stalled result lost")
  `ADM_ASSERT(a_root_ge_a, !sv[MAG_W] || (sq_root[MAG_W] >= sq_it[MAG_W].a), "root below move magnitude")
endmodule

// ===== rtl/core/arcade_drive_trig_mixer.sv =====
// ---------------------------------------------------------------------------
// Arcade drive trigonometric mixer
// Scales move and rotate, then splits them into left and right drive.
//
//   channel  ports                           handshake
//   input    move_cmd, rotate_cmd            push / full
//   result   left_drive, right_drive         empty / pop
//   config   cfg_index, cfg_data             cfg_valid / cfg_ready
//
// One item per cycle sustained while results keep being popped; the root and
// divider pipelines each resolve one bit per stage.
// Reset clears queues and pipeline valids and loads the default gains.
// A stalled pop holds the whole back end once the result queue is full and a
// new result is waiting; push stays open until the four-entry queue fills.
// ---------------------------------------------------------------------------
module arcade_drive_trig_mixer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [adm_pkg::DATA_W-1:0] move_cmd,
  input  logic signed [adm_pkg::DATA_W-1:0] rotate_cmd,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [adm_pkg::DATA_W-1:0] left_drive,
  output logic signed [adm_pkg::DATA_W-1:0] right_drive,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [adm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [adm_pkg::GAIN_W-1:0]        cfg_data
);
  import adm_pkg::*;

  mid_t f_item;
  mid_t q_item;
  logic q_empty;
  logic take;
  res_t res;

  assign cfg_ready = 1'b1;

  adm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .move_cmd   (move_cmd),
    .rotate_cmd (rotate_cmd),
    .item       (f_item)
  );

  adm_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (f_item),
    .full    (full),
    .rd_en   (take),
    .rd_data (q_item),
    .empty   (q_empty)
  );

  adm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_item  (q_item),
    .in_empty (q_empty),
    .take     (take),
    .res      (res),
    .empty    (empty),
    .pop      (pop)
  );

  assign left_drive  = res.left;
  assign right_drive = res.right;
endmodule

// ===== test/tb_top.sv =====
// ---------------------------------------------------------------------------
// Arcade drive mixer testbench
// Drives move/rotate requests through the push/full port, predicts left and
// right drive from the gains in force, and checks each popped result in
// order. Gains are reprogrammed between phases while the mixer is idle.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import adm_pkg::*;

  localparam int LATENCY    = 2 * (FRAC_BITS + 1) + 3;
  localparam int WDOG_LIMIT = 5000;
  localparam int HOLD_LEN   = 300;

  typedef struct packed {
    logic [DATA_W-1:0] move;
    logic [DATA_W-1:0] rotate;
  } drive_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty, cfg_ready;
  logic signed [DATA_W-1:0] move_cmd = '0;
  logic signed [DATA_W-1:0] rotate_cmd = '0;
  logic signed [DATA_W-1:0] left_drive, right_drive;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0] cfg_data = '0;

  arcade_drive_trig_mixer uut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .move_cmd(move_cmd), .rotate_cmd(rotate_cmd),
    .empty(empty), .pop(pop), .left_drive(left_drive), .right_drive(right_drive),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [GAIN_W-1:0] gain_mp, gain_mn, gain_rp, gain_rn;
  drive_req_t pending_reqs[$];
  res_t       expected_drive[$];
  int  mismatches = 0;
  int  results_seen = 0;
  int  idle_cycles = 0;
  int  hold_off = 0;
  bit  calm = 1'b0;
  bit  in_fire = 1'b0;

  initial forever #6 clk = ~clk;

  function automatic logic [MAG_W:0] scale_mag(logic [DATA_W-1:0] raw,
                                               logic [GAIN_W-1:0] gp,
                                               logic [GAIN_W-1:0] gn);
    logic [DATA_W:0] mag;
    logic [63:0] p;
    mag = raw[DATA_W-1] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    p = (64'(mag) * 64'(raw[DATA_W-1] ? gn : gp) + (64'd1 << (FRAC_BITS - 1)))
        >> FRAC_BITS;
    return (p > (64'd1 << FRAC_BITS)) ? (MAG_W + 1)'(1 << FRAC_BITS) : (MAG_W + 1)'(p);
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic res_t mix_drive(drive_req_t q);
    logic [63:0] a, r, h, outer, inner, lw, rw;
    res_t o;
    a = 64'(scale_mag(q.move, gain_mp, gain_mn));
    r = 64'(scale_mag(q.rotate, gain_rp, gain_rn));
    if (a == 0) begin
      o.left = '0;
      o.right = '0;
      return o;
    end
    h = root_floor(a * a + r * r);
    outer = (a * a + (h >> 1)) / h;
    inner = a - (a * r + (h >> 1)) / h;
    if (r != 0 && !q.rotate[DATA_W-1]) begin
      lw = outer;
      rw = inner;
    end else begin
      lw = inner;
      rw = outer;
    end
    if (!q.move[DATA_W-1]) begin
      lw = 0 - lw;
      rw = 0 - rw;
    end
    o.left = lw[DATA_W-1:0];
    o.right = rw[DATA_W-1:0];
    return o;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || in_fire) begin
      if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 36)) begin
        push <= 1'b1;
        move_cmd <= pending_reqs[0].move;
        rotate_cmd <= pending_reqs[0].rotate;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // queue the prediction at acceptance, so gains in force are used
  always @(posedge clk) begin
    in_fire <= !rst && push && !full;
    if (!rst && push && !full) begin
      expected_drive.push_back(mix_drive({move_cmd, rotate_cmd}));
      void'(pending_reqs.pop_front());
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      pop <= 1'b0;
    end else begin
      pop <= calm || ($urandom_range(99) >= 36);
    end
  end

  // monitor
  always @(posedge clk) begin
    res_t e;
    if (!rst && pop && !empty) begin
      results_seen <= results_seen + 1;
      if (expected_drive.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %0d %0d", left_drive, right_drive);
      end else begin
        e = expected_drive.pop_front();
        if (e.left !== left_drive || e.right !== right_drive) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected %0d %0d, got %0d %0d", $signed(e.left),
                     $signed(e.right), left_drive, right_drive);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("watchdog expired");
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic write_gain(cfg_reg_t idx, logic [GAIN_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MOVE_GAIN_POS:   gain_mp = val;
      REG_MOVE_GAIN_NEG:   gain_mn = val;
      REG_ROTATE_GAIN_POS: gain_rp = val;
      default:             gain_rn = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_drive.size() > 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] rand_cmd();
    int k;
    k = $urandom_range(9);
    if (k < 6) return DATA_W'($urandom_range(32768) - 16384);
    if (k < 8) return DATA_W'($urandom_range(40) - 20);
    return DATA_W'($urandom);
  endfunction

  task automatic random_phase(int n);
    repeat (n) pending_reqs.push_back({rand_cmd(), rand_cmd()});
    drain();
  endtask

  initial begin
    logic [DATA_W-1:0] edges[8];
    edges = '{16'h4000, 16'hC000, 16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF,
              16'h8000, 16'h2000};
    gain_mp = 16550; gain_mn = 27307; gain_rp = 16550; gain_rn = 16550;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (edges[i]) begin
      pending_reqs.push_back({edges[i], edges[(i + 3) % 8]});
      pending_reqs.push_back({edges[(i + 5) % 8], edges[i]});
    end
    pending_reqs.push_back({16'h4000, 16'h0000});
    pending_reqs.push_back({16'hC000, 16'h4000});
    drain();

    // long receiver stall with the sender still offering requests
    hold_off = HOLD_LEN;
    random_phase(400);

    write_gain(REG_MOVE_GAIN_POS, 15'h7FFF);
    write_gain(REG_MOVE_GAIN_NEG, 15'h0000);
    write_gain(REG_ROTATE_GAIN_POS, 15'h0000);
    write_gain(REG_ROTATE_GAIN_NEG, 15'h7FFF);
    random_phase(300);

    write_gain(REG_MOVE_GAIN_POS, 15'h0001);
    write_gain(REG_MOVE_GAIN_NEG, 15'h7FFF);
    write_gain(REG_ROTATE_GAIN_POS, 15'h7FFF);
    write_gain(REG_ROTATE_GAIN_NEG, 15'h0001);
    calm = 1'b1;
    random_phase(300);
    calm = 1'b0;

    repeat (3) begin
      write_gain(REG_MOVE_GAIN_POS, GAIN_W'($urandom));
      write_gain(REG_MOVE_GAIN_NEG, GAIN_W'($urandom));
      write_gain(REG_ROTATE_GAIN_POS, GAIN_W'($urandom));
      write_gain(REG_ROTATE_GAIN_NEG, GAIN_W'($urandom));
      random_phase(330);
    end

    $display("covered %0d results over directed edges, extreme and random gains",
             results_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

// ===== arcade_drive_trig_mixer.f =====
+incdir+rtl/core
rtl/core/adm_pkg.sv
rtl/core/adm_front.sv
rtl/core/adm_fifo.sv
rtl/core/adm_back.sv
rtl/core/arcade_drive_trig_mixer.sv
test/tb_top.sv
